// ----- design/uccp_pkg.sv -----
// ----------------------------------------------------------------------------
// uccp_pkg
// shared types, widths and edge table for the channel point classifier
// ----------------------------------------------------------------------------
`default_nettype none

package uccp_pkg;

    localparam int VERTEX_COUNT = 8;
    localparam int VW           = 34;   // vertex coordinate width
    localparam int DW           = 36;   // difference / dot product width
    localparam int CELL_STAGES  = 3;
    // front register, front compute, cell chain, output register
    localparam int LATENCY      = 2 + CELL_STAGES * VERTEX_COUNT + 1;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_OUTER_LEFT     = 3'd0,
        REG_OUTER_BOTTOM   = 3'd1,
        REG_OUTER_RIGHT    = 3'd2,
        REG_OUTER_TOP      = 3'd3,
        REG_WALL_THICKNESS = 3'd4,
        REG_PLANE_Z        = 3'd5,
        REG_NEAR_TOLERANCE = 3'd6
    } reg_idx_t;

    typedef logic signed [VW-1:0] vtx_t;
    typedef logic signed [DW-1:0] dif_t;
    typedef logic signed [1:0]    dir_t;

    // direction of each edge of the u outline, counter-clockwise
    localparam dir_t EDGE_DX [VERTEX_COUNT] = '{
        2'sd1, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd0
    };
    localparam dir_t EDGE_DY [VERTEX_COUNT] = '{
        2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, -2'sd1
    };

    typedef struct packed {
        logic               valid;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [63:0]        dz2;
        logic [61:0]        tol2;
        logic               on_plane;
        logic               nbox;
        logic               pre;
        logic               tol_nz;
        logic               err;
        logic               parity;
        logic               near;
    } chain_t;

    // multiply by a direction component in {-1, 0, 1}
    function automatic dif_t dmul(input dir_t d, input dif_t v);
        dif_t r;
        if (d == 2'sd1)
            r = v;
        else if (d == -2'sd1)
            r = -v;
        else
            r = '0;
        return r;
    endfunction

    // magnitude, saturated to 32 bits
    function automatic logic [31:0] mag32(input dif_t v);
        logic [DW-1:0] a;
        a = v[DW-1] ? DW'(-v) : DW'(v);
        if (|a[DW-1:32])
            return 32'hFFFF_FFFF;
        return a[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/u_channel_point_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// u_channel_point_classifier_unit
// classifies a point against an eight-vertex u-shaped channel polygon
// ----------------------------------------------------------------------------
// A point request is taken whenever start is high (busy stays low), one per
// clock, and its four flags come back on the result ports with a one-cycle
// done strobe, in request order. The receiver cannot stall: results must be
// captured in the cycle done is high. A request passes the input and front-end
// registers, the chain of edge cells (geometry, square, sum and compare stages
// in each) and the output register. The user must write the polygon registers
// through the apb port only while no request is in flight; the block does not
// enforce it. Vertices are registered off the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module u_channel_point_classifier_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // apb configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [uccp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // point request
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [31:0]           point_x,
    input  wire logic signed [31:0]           point_y,
    input  wire logic signed [31:0]           point_z,
    input  wire logic                         within_only,
    // result
    output logic                              done,
    output logic                              is_inside,
    output logic                              is_near_box,
    output logic                              is_near_boundary,
    output logic                              config_error
);
    import uccp_pkg::*;

    // configuration registers
    logic signed [31:0] left_reg, bottom_reg, right_reg, top_reg, plane_reg;
    logic [30:0]        wall_reg, tol_reg;
    reg_idx_t           widx;
    logic               wr_en;

    // derived vertices, registered off the configuration
    vtx_t vx_reg [VERTEX_COUNT];
    vtx_t vy_reg [VERTEX_COUNT];
    vtx_t vx_next [VERTEX_COUNT];
    vtx_t vy_next [VERTEX_COUNT];
    logic err_reg, err_next;

    // front registers
    logic               f0_valid_reg;
    logic signed [31:0] f0_x_reg, f0_y_reg, f0_z_reg;
    logic               f0_within_reg;
    chain_t             f1_reg, f1_next;
    logic [31:0]        dzm;

    chain_t chain [VERTEX_COUNT+1];

    logic done_reg, inside_reg, nbox_reg, nbnd_reg, err_out_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 32'sd0;
            bottom_reg <= 32'sd0;
            right_reg  <= 32'sd262144;
            top_reg    <= 32'sd262144;
            wall_reg   <= 31'd65536;
            plane_reg  <= 32'sd0;
            tol_reg    <= 31'd0;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_OUTER_LEFT:     left_reg   <= pwdata;
                REG_OUTER_BOTTOM:   bottom_reg <= pwdata;
                REG_OUTER_RIGHT:    right_reg  <= pwdata;
                REG_OUTER_TOP:      top_reg    <= pwdata;
                REG_WALL_THICKNESS: wall_reg   <= pwdata[30:0];
                REG_PLANE_Z:        plane_reg  <= pwdata;
                REG_NEAR_TOLERANCE: tol_reg    <= pwdata[30:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_OUTER_LEFT:     prdata = left_reg;
            REG_OUTER_BOTTOM:   prdata = bottom_reg;
            REG_OUTER_RIGHT:    prdata = right_reg;
            REG_OUTER_TOP:      prdata = top_reg;
            REG_WALL_THICKNESS: prdata = {1'b0, wall_reg};
            REG_PLANE_Z:        prdata = plane_reg;
            REG_NEAR_TOLERANCE: prdata = {1'b0, tol_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // u outline: outer box, then the inner walls, counter-clockwise
    always_comb
    begin
        vtx_t l, b, r, t, w;
        l = VW'(left_reg);
        b = VW'(bottom_reg);
        r = VW'(right_reg);
        t = VW'(top_reg);
        w = VW'({1'b0, wall_reg});
        vx_next[0] = l;     vy_next[0] = b;
        vx_next[1] = r;     vy_next[1] = b;
        vx_next[2] = r;     vy_next[2] = t;
        vx_next[3] = r - w; vy_next[3] = t - w;
        vx_next[4] = r - w; vy_next[4] = b + w;
        vx_next[5] = l + w; vy_next[5] = b + w;
        vx_next[6] = l + w; vy_next[6] = t - w;
        vx_next[7] = l;     vy_next[7] = t;
        // inverted box, zero wall or walls that close the channel
        err_next = !(r > l && t > b && w != '0 && (r - l) > (w <<< 1)
                     && (t - b) > (w <<< 1));
    end

    always_ff @(posedge clk)
    begin
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        err_reg <= err_next;
    end

    // front end: plane distance, squared budget and box tests
    always_comb
    begin
        vtx_t px, py, tol, g;
        logic signed [32:0] dz;
        px  = VW'(f0_x_reg);
        py  = VW'(f0_y_reg);
        tol = VW'({1'b0, tol_reg});
        g   = f0_within_reg ? '0 : tol;
        dz  = 33'(f0_z_reg) - 33'(plane_reg);
        dzm = dz[32] ? 32'(-dz) : dz[31:0];
        f1_next          = '0;
        f1_next.valid    = f0_valid_reg;
        f1_next.px       = f0_x_reg;
        f1_next.py       = f0_y_reg;
        f1_next.dz2      = dzm * dzm;
        f1_next.tol2     = tol_reg * tol_reg;
        f1_next.on_plane = f0_z_reg == plane_reg;
        f1_next.nbox     = px >= vx_reg[0] - tol && px <= vx_reg[1] + tol
                           && py >= vy_reg[0] - tol && py <= vy_reg[2] + tol;
        f1_next.pre      = px >= vx_reg[0] - g && px <= vx_reg[1] + g
                           && py >= vy_reg[0] - g && py <= vy_reg[2] + g;
        f1_next.tol_nz   = tol_reg != '0;
        f1_next.err      = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_reg       <= '0;
        end
        else
        begin
            f0_valid_reg <= start && !busy;
            f1_reg       <= f1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f0_x_reg      <= point_x;
        f0_y_reg      <= point_y;
        f0_z_reg      <= point_z;
        f0_within_reg <= within_only;
    end

    // chain of edge cells, each request walks every edge in turn
    assign chain[0] = f1_reg;

    for (genvar e = 0; e < VERTEX_COUNT; e++)
    begin : g_cell
        localparam int NXT = (e + 1) % VERTEX_COUNT;
        uccp_edge_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ax        (vx_reg[e]),
            .ay        (vy_reg[e]),
            .bx        (vx_reg[NXT]),
            .by        (vy_reg[NXT]),
            .dx        (EDGE_DX[e]),
            .dy        (EDGE_DY[e]),
            .chain_in  (chain[e]),
            .chain_out (chain[e+1])
        );
    end

    // bad configuration masks every flag but its own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            inside_reg  <= 1'b0;
            nbox_reg    <= 1'b0;
            nbnd_reg    <= 1'b0;
            err_out_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= chain[VERTEX_COUNT].valid;
            inside_reg  <= !chain[VERTEX_COUNT].err && chain[VERTEX_COUNT].parity
                           && chain[VERTEX_COUNT].on_plane;
            nbox_reg    <= !chain[VERTEX_COUNT].err && chain[VERTEX_COUNT].nbox;
            nbnd_reg    <= !chain[VERTEX_COUNT].err && chain[VERTEX_COUNT].pre
                           && chain[VERTEX_COUNT].tol_nz && chain[VERTEX_COUNT].near;
            err_out_reg <= chain[VERTEX_COUNT].err;
        end
    end

    assign done             = done_reg;
    assign is_inside        = inside_reg;
    assign is_near_box      = nbox_reg;
    assign is_near_boundary = nbnd_reg;
    assign config_error     = err_out_reg;

    // every request returns exactly once after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not return after pipeline latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching request");

    a_err_masks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && config_error) |-> (!is_inside && !is_near_box && !is_near_boundary))
        else $error("flags set under bad configuration");

    a_zero_tol: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_near_boundary) |-> (tol_reg != '0))
        else $error("boundary hit with zero tolerance");

endmodule

`default_nettype wire

// ----- design/uccp_edge_cell.sv -----
// ----------------------------------------------------------------------------
// uccp_edge_cell
// one polygon edge: crossing toggle and squared-distance nearness, 3 stages
// ----------------------------------------------------------------------------
`default_nettype none

module uccp_edge_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  uccp_pkg::vtx_t       ax,
    input  uccp_pkg::vtx_t       ay,
    input  uccp_pkg::vtx_t       bx,
    input  uccp_pkg::vtx_t       by,
    input  uccp_pkg::dir_t       dx,
    input  uccp_pkg::dir_t       dy,
    input  uccp_pkg::chain_t     chain_in,
    output uccp_pkg::chain_t     chain_out
);
    import uccp_pkg::*;

    dif_t px, py, apx, apy, bpx, bpy, dota, dotb, perp, ex, ey, xline;
    dir_t slope;
    logic pre_a, past_b, endpt, diag, toggle;

    chain_t      a_reg, a_next, b_reg, o_reg, o_next;
    logic [31:0] m1_reg, m1_next, m2_reg, m2_next;
    logic        sa_reg, sa_next, sb_reg;
    logic [63:0] sq1_reg, sq2_reg;
    logic [66:0] sum;
    logic [66:0] lim;

    // stage a: geometry with add/sub only
    always_comb
    begin
        px     = DW'(chain_in.px);
        py     = DW'(chain_in.py);
        apx    = px - DW'(ax);
        apy    = py - DW'(ay);
        bpx    = px - DW'(bx);
        bpy    = py - DW'(by);
        dota   = dmul(dx, apx) + dmul(dy, apy);
        dotb   = dmul(dx, bpx) + dmul(dy, bpy);
        pre_a  = dota <= 0;
        past_b = !pre_a && dotb >= 0;
        endpt  = pre_a || past_b;
        diag   = (dx != 2'sd0) && (dy != 2'sd0);
        ex     = pre_a ? apx : bpx;
        ey     = pre_a ? apy : bpy;
        perp   = dmul(dy, apx) - dmul(dx, apy);
        m1_next = endpt ? mag32(ex) : mag32(perp);
        m2_next = endpt ? mag32(ey) : 32'd0;
        sa_next = !endpt && diag;
        // slope dx/dy equals dx*dy for unit steps
        if (dx == 2'sd0)
            slope = 2'sd0;
        else
            slope = (dx == dy) ? 2'sd1 : -2'sd1;
        xline  = DW'(ax) + dmul(slope, py - DW'(ay));
        toggle = ((DW'(ay) > py) != (DW'(by) > py)) && (px < xline);
        a_next = chain_in;
        a_next.parity = chain_in.parity ^ toggle;
    end

    // stage c: sum of squares against the budget
    always_comb
    begin
        sum = 67'(sq1_reg) + 67'(sq2_reg) + (sb_reg ? {2'b0, b_reg.dz2, 1'b0}
                                                    : {3'b0, b_reg.dz2});
        lim = sb_reg ? {4'b0, b_reg.tol2, 1'b0} : {5'b0, b_reg.tol2};
        o_next = b_reg;
        o_next.near = b_reg.near | (sum < lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            o_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= a_reg;
            o_reg <= o_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg  <= m1_next;
        m2_reg  <= m2_next;
        sa_reg  <= sa_next;
        sq1_reg <= m1_reg * m1_reg;
        sq2_reg <= m2_reg * m2_reg;
        sb_reg  <= sa_reg;
    end

    assign chain_out = o_reg;

endmodule

`default_nettype wire
